// ===== rtl/ttst_pkg.sv =====
// shared types, constants and string rom for the template tag translator
package ttst_pkg;

  // wrapper strings the back end can expand
  typedef enum logic [2:0] {
    STR_NONE,
    STR_OPEN_LIT,
    STR_CLOSE_TAG,
    STR_CLOSE_END,
    STR_OPEN_EXPR,
    STR_CLOSE_EXPR
  } str_id_t;

  // one request from the parser: a wrapper string followed by up to two bytes
  typedef struct packed {
    str_id_t    str;
    logic [1:0] n_chars;
    logic [7:0] c0;
    logic [7:0] c1;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_QM  = 8'h3F;

  localparam int ROM_DEPTH = 32;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

  // all wrapper strings packed back to back
  localparam logic [7:0] STR_ROM [ROM_DEPTH] = '{
    8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h28, 8'h5B, 8'h3D, 8'h3D, 8'h5B, 8'h0A,
    8'h5D, 8'h3D, 8'h3D, 8'h5D, 8'h29, 8'h0A,
    8'h0A, 8'h5D, 8'h3D, 8'h3D, 8'h5D, 8'h29,
    8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h28,
    8'h29, 8'h0A,
    8'h00
  };

  function automatic logic [3:0] str_len(input str_id_t id);
    logic [3:0] r;
    unique case (id)
      STR_OPEN_LIT:   r = 4'd11;
      STR_CLOSE_TAG:  r = 4'd6;
      STR_CLOSE_END:  r = 4'd6;
      STR_OPEN_EXPR:  r = 4'd6;
      STR_CLOSE_EXPR: r = 4'd2;
      default:        r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [ROM_AW-1:0] str_base(input str_id_t id);
    logic [ROM_AW-1:0] r;
    unique case (id)
      STR_OPEN_LIT:   r = ROM_AW'(0);
      STR_CLOSE_TAG:  r = ROM_AW'(11);
      STR_CLOSE_END:  r = ROM_AW'(17);
      STR_OPEN_EXPR:  r = ROM_AW'(23);
      STR_CLOSE_EXPR: r = ROM_AW'(29);
      default:        r = ROM_AW'(31);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ttst_front.sv =====
// parser front end: tracks tag state and maps each item to at most one request
module ttst_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          kind,
  input  logic [7:0]    char_in,
  output logic          cmd_valid,
  output ttst_pkg::cmd_t cmd
);
  import ttst_pkg::*;

  typedef enum logic [3:0] {
    S_DEFAULT, S_LIT, S_LIT_LT, S_LIT_BLANK, S_LT,
    S_TAG, S_EXPR, S_EXPR_Q, S_STMT, S_STMT_Q
  } state_t;

  state_t state, state_next;
  logic   has_out;
  logic   blank, space;

  assign blank = (char_in == CH_SP) || (char_in == CH_TAB);
  assign space = blank || (char_in == CH_NL) || (char_in == CH_VT) ||
                 (char_in == CH_FF) || (char_in == CH_CR);

  always_comb begin
    state_next  = state;
    has_out     = 1'b0;
    cmd.str     = STR_NONE;
    cmd.n_chars = 2'd0;
    cmd.c0      = char_in;
    cmd.c1      = char_in;
    if (kind) begin
      if (state == S_LIT || state == S_LIT_BLANK) begin
        has_out = 1'b1;
        cmd.str = STR_CLOSE_END;
      end
      state_next = S_DEFAULT;
    end else begin
      unique case (state)
        S_LIT: begin
          if (char_in == CH_LT) begin
            state_next = S_LIT_LT;
          end else if (blank) begin
            has_out     = 1'b1;
            cmd.n_chars = 2'd1;
            cmd.c0      = CH_SP;
            state_next  = S_LIT_BLANK;
          end else begin
            has_out     = 1'b1;
            cmd.n_chars = 2'd1;
          end
        end
        S_LIT_BLANK: begin
          if (char_in == CH_LT) begin
            state_next = S_LIT_LT;
          end else if (!blank) begin
            has_out     = 1'b1;
            cmd.n_chars = 2'd1;
            state_next  = S_LIT;
          end
        end
        S_LIT_LT: begin
          has_out = 1'b1;
          if (char_in == CH_QM) begin
            cmd.str    = STR_CLOSE_TAG;
            state_next = S_TAG;
          end else begin
            cmd.n_chars = 2'd2;
            cmd.c0      = CH_LT;
            state_next  = S_LIT;
          end
        end
        S_LT: begin
          if (char_in == CH_QM) begin
            state_next = S_TAG;
          end else begin
            has_out     = 1'b1;
            cmd.str     = STR_OPEN_LIT;
            cmd.n_chars = 2'd2;
            cmd.c0      = CH_LT;
            state_next  = S_LIT;
          end
        end
        S_TAG: begin
          has_out = 1'b1;
          if (char_in == CH_EQ) begin
            cmd.str    = STR_OPEN_EXPR;
            state_next = S_EXPR;
          end else begin
            cmd.n_chars = 2'd1;
            state_next  = S_STMT;
          end
        end
        S_EXPR, S_STMT: begin
          if (char_in == CH_QM) begin
            state_next = (state == S_EXPR) ? S_EXPR_Q : S_STMT_Q;
          end else begin
            has_out     = 1'b1;
            cmd.n_chars = 2'd1;
          end
        end
        S_EXPR_Q: begin
          has_out = 1'b1;
          if (char_in == CH_GT) begin
            cmd.str    = STR_CLOSE_EXPR;
            state_next = S_DEFAULT;
          end else begin
            cmd.n_chars = 2'd2;
            cmd.c0      = CH_QM;
            state_next  = S_EXPR;
          end
        end
        S_STMT_Q: begin
          has_out = 1'b1;
          if (char_in == CH_GT) begin
            cmd.n_chars = 2'd1;
            cmd.c0      = CH_NL;
            state_next  = S_DEFAULT;
          end else begin
            cmd.n_chars = 2'd2;
            cmd.c0      = CH_QM;
            state_next  = S_STMT;
          end
        end
        default: begin
          if (char_in == CH_LT) begin
            state_next = S_LT;
          end else if (!space) begin
            has_out     = 1'b1;
            cmd.str     = STR_OPEN_LIT;
            cmd.n_chars = 2'd1;
            state_next  = S_LIT;
          end else begin
            state_next = S_DEFAULT;
          end
        end
      endcase
    end
  end

  assign cmd_valid = accept && has_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_DEFAULT;
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ttst_queue.sv =====
// small register queue between parser and byte expander
module ttst_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ttst_back.sv =====
// back end: expands queued requests into script bytes, one per cycle while pop is high
module ttst_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  ttst_pkg::cmd_t head,
  output logic           head_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     char_out,
  output logic           last
);
  import ttst_pkg::*;

  logic [3:0]        idx;
  logic [3:0]        len;
  logic [3:0]        total;
  logic [ROM_AW-1:0] rom_addr;
  logic [7:0]        byte_sel;
  logic              byte_last;
  logic              out_valid;
  logic              load;

  assign len      = str_len(head.str);
  assign total    = len + {2'b00, head.n_chars};
  assign rom_addr = str_base(head.str) + {1'b0, idx};

  always_comb begin
    if (idx < len) begin
      byte_sel = STR_ROM[rom_addr];
    end else if (idx == len) begin
      byte_sel = head.c0;
    end else begin
      byte_sel = head.c1;
    end
  end

  assign byte_last = (idx == total - 4'd1);
  assign empty     = !out_valid;
  assign load      = head_valid && (!out_valid || pop);
  assign head_pop  = load && byte_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= byte_last ? 4'd0 : idx + 4'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_out <= byte_sel;
      last     <= byte_last;
    end
  end

endmodule

// ===== rtl/template_tag_to_script_translator.sv =====
// top level of the template tag to script translator
// Template bytes go in through a queue-style port: push with kind and
// char_in, accepted when push is high and full is low. Script bytes come out
// the same way: char_out and last are valid while empty is low and are taken
// when pop is high. last marks the final byte produced for one input item.
// The parser takes one item per cycle while full is low and queues a request
// for each item that produces bytes in a QUEUE_DEPTH-entry queue; the
// expander reads the queue and sends one byte per cycle while pop is high,
// built from a string rom and the request. Throughput is one item per cycle
// while items produce at most one byte each and pop stays high; a longer
// item (up to thirteen bytes) holds the expander until its last byte is
// loaded, and full rises once the queue fills behind it. Items that produce
// no bytes never enter the queue. When pop stays low the output register
// holds its byte and the queue absorbs up to QUEUE_DEPTH more requests
// before full.
// Reset clears the parser to its default state and empties the queue and
// output register; no item is lost or created by stalls on either side.
module template_tag_to_script_translator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       kind,
  input  logic [7:0] char_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out,
  output logic       last
);
  import ttst_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic head_valid;
  logic head_pop;
  cmd_t head;
  logic [CMD_W-1:0] head_bits;

  assign accept = push && !full;
  assign head   = cmd_t'(head_bits);

  ttst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .char_in   (char_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  ttst_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_valid),
    .wr_data  (cmd),
    .full     (full),
    .rd_en    (head_pop),
    .rd_valid (head_valid),
    .rd_data  (head_bits)
  );

  ttst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .char_out   (char_out),
    .last       (last)
  );

endmodule

// ===== tb/template_tag_to_script_translator_tb.sv =====
// self-checking testbench for the template tag to script translator
module template_tag_to_script_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttst_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_PER_PHASE = 100;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } item_kind_e;

  typedef enum logic [3:0] {
    PS_DEFAULT,
    PS_LIT,
    PS_LIT_LT,
    PS_LIT_BLANK,
    PS_LT,
    PS_TAG,
    PS_EXPR,
    PS_EXPR_Q,
    PS_STMT,
    PS_STMT_Q
  } parse_state_e;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } script_byte_t;

  class script_tracker;
    parse_state_e pstate;
    script_byte_t expected_script[$];
    int unsigned  errors;

    function new();
      pstate = PS_DEFAULT;
      errors = 0;
    endfunction

    function void emit_byte(logic [7:0] b);
      script_byte_t e;
      e.ch = b;
      e.last = 1'b0;
      expected_script.push_back(e);
    endfunction

    function void emit_text(string s);
      for (int i = 0; i < s.len(); i++) emit_byte(s[i]);
    endfunction

    // returns 1 when the item produced bytes or moved the parser
    function bit note_template_item(item_kind_e k, logic [7:0] c);
      int unsigned  n0;
      parse_state_e prev;
      script_byte_t e;
      n0 = expected_script.size();
      prev = pstate;
      if (k == KIND_END) begin
        if (pstate inside {PS_LIT, PS_LIT_BLANK}) emit_text("\n]==])");
        pstate = PS_DEFAULT;
      end else begin
        case (pstate)
          PS_LIT: begin
            if (c == CH_LT) begin
              pstate = PS_LIT_LT;
            end else if (c inside {CH_SP, CH_TAB}) begin
              emit_byte(CH_SP);
              pstate = PS_LIT_BLANK;
            end else begin
              emit_byte(c);
            end
          end
          PS_LIT_BLANK: begin
            if (c == CH_LT) begin
              pstate = PS_LIT_LT;
            end else if (!(c inside {CH_SP, CH_TAB})) begin
              emit_byte(c);
              pstate = PS_LIT;
            end
          end
          PS_LIT_LT: begin
            if (c == CH_QM) begin
              emit_text("]==])\n");
              pstate = PS_TAG;
            end else begin
              emit_byte(CH_LT);
              emit_byte(c);
              pstate = PS_LIT;
            end
          end
          PS_LT: begin
            if (c == CH_QM) begin
              pstate = PS_TAG;
            end else begin
              emit_text("print([==[\n");
              emit_byte(CH_LT);
              emit_byte(c);
              pstate = PS_LIT;
            end
          end
          PS_TAG: begin
            if (c == CH_EQ) begin
              emit_text("print(");
              pstate = PS_EXPR;
            end else begin
              emit_byte(c);
              pstate = PS_STMT;
            end
          end
          PS_EXPR: begin
            if (c == CH_QM) pstate = PS_EXPR_Q;
            else emit_byte(c);
          end
          PS_EXPR_Q: begin
            if (c == CH_GT) begin
              emit_text(")\n");
              pstate = PS_DEFAULT;
            end else begin
              emit_byte(CH_QM);
              emit_byte(c);
              pstate = PS_EXPR;
            end
          end
          PS_STMT: begin
            if (c == CH_QM) pstate = PS_STMT_Q;
            else emit_byte(c);
          end
          PS_STMT_Q: begin
            if (c == CH_GT) begin
              emit_byte(CH_NL);
              pstate = PS_DEFAULT;
            end else begin
              emit_byte(CH_QM);
              emit_byte(c);
              pstate = PS_STMT;
            end
          end
          default: begin
            if (c == CH_LT) begin
              pstate = PS_LT;
            end else if (!(c inside {CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR})) begin
              emit_text("print([==[\n");
              emit_byte(c);
              pstate = PS_LIT;
            end else begin
              pstate = PS_DEFAULT;
            end
          end
        endcase
      end
      if (expected_script.size() > n0) begin
        e = expected_script.pop_back();
        e.last = 1'b1;
        expected_script.push_back(e);
      end
      return (expected_script.size() > n0) || (pstate != prev);
    endfunction

    function void check_script_byte(logic [7:0] ch, logic lst);
      script_byte_t e;
      if (expected_script.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected script byte %02h last=%0b", ch, lst);
        return;
      end
      e = expected_script.pop_front();
      if (ch !== e.ch || lst !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("script byte mismatch: expected %02h last=%0b, got %02h last=%0b",
                   e.ch, e.last, ch, lst);
      end
    endfunction

    function int unsigned pending();
      return expected_script.size();
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       kind = 1'b0;
  logic [7:0] char_in = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] char_out;
  logic       last;

  script_tracker board = new();
  int unsigned   useful_items = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;

  logic [7:0] ws_chars [6] = '{CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};

  template_tag_to_script_translator uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .kind    (kind),
    .char_in (char_in),
    .empty   (empty),
    .pop     (pop),
    .char_out(char_out),
    .last    (last)
  );

  always begin
    clk = 1'b1;
    #5ns;
    clk = 1'b0;
    #5ns;
  end

  initial begin
    forever begin
      @(negedge clk);
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_script_byte(char_out, last);
  end

  // counts cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("template_tag_to_script_translator_tb failed");
        $finish;
      end
    end
  end

  // entered and left at a falling edge; push stays high until the next call decides
  task automatic send_item(item_kind_e k, logic [7:0] c);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    kind <= k;
    char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    if (board.note_template_item(k, c)) useful_items++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i]);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 75) return ($urandom_range(1) != 0) ? CH_SP : CH_TAB;
    if (r < 85) return ($urandom_range(1) != 0) ? CH_LT : CH_QM;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_random(int unsigned target);
    int unsigned goal;
    int unsigned pick;
    goal = useful_items + target;
    while (useful_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 12)) send_item(KIND_CHAR, text_byte());
      end else if (pick < 55) begin
        send_text("<?=");
        repeat ($urandom_range(0, 8)) send_item(KIND_CHAR, text_byte());
        send_text("?>");
      end else if (pick < 70) begin
        send_text("<?");
        repeat ($urandom_range(0, 8)) send_item(KIND_CHAR, text_byte());
        send_text("?>");
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_item(KIND_CHAR, ws_chars[$urandom_range(5)]);
      end else if (pick < 88) begin
        send_item(KIND_END, 8'($urandom_range(255)));
      end else begin
        // noise and broken tags
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(9) == 0) send_item(KIND_END, 8'($urandom_range(255)));
          else send_item(KIND_CHAR, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    int unsigned gaps [4];
    int unsigned stalls [4];
    gaps = '{0, 65, 0, 19};
    stalls = '{0, 0, 65, 19};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // leading whitespace is dropped, then extremes open a literal
    foreach (ws_chars[i]) send_item(KIND_CHAR, ws_chars[i]);
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, CH_SP);
    send_item(KIND_CHAR, CH_TAB);
    send_item(KIND_END, 8'hFF);
    // lone lt from the default state, then tag after literal text
    send_text("<a");
    send_item(KIND_CHAR, 8'hFF);
    send_text("<?=?y?>");
    send_text("<?c?>");
    send_item(KIND_CHAR, 8'h78);
    send_item(KIND_END, 8'h00);

    for (int p = 0; p < 4; p++) begin
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      run_random(RANDOM_PER_PHASE);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("template_tag_to_script_translator_tb passed");
    end else begin
      $display("template_tag_to_script_translator_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ttst_pkg.sv
rtl/ttst_front.sv
rtl/ttst_queue.sv
rtl/ttst_back.sv
rtl/template_tag_to_script_translator.sv
tb/template_tag_to_script_translator_tb.sv
